>>> src/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the distinct circle counter
// Point and result transaction types, sequencer states and set constants.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned NumPoints  = 7;
  localparam int unsigned NumTriples = 35;
  localparam int unsigned KeyW       = 16;

  typedef struct packed {
    logic [2:0] py_coord;
    logic [2:0] px_coord;
  } in_t;

  typedef struct packed {
    logic [5:0] circle_count;
    logic       degenerate;
  } out_t;

  typedef struct packed {
    logic signed [KeyW-1:0] a;
    logic signed [KeyW-1:0] b;
    logic signed [KeyW-1:0] c;
    logic signed [KeyW-1:0] d;
  } key_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_GEOM,
    ST_KEYC,
    ST_GCD,
    ST_DIV,
    ST_CMP_RD,
    ST_CMP,
    ST_OUT
  } state_e;

endpackage

>>> src/distinct_circle_counter.sv
// ----------------------------------------------------------------------------
// distinct_circle_counter: distinct circles through seven grid points
// Loads seven points, reduces each non-collinear triple to a circle key with a
// shared gcd and divide unit and counts distinct keys by pairwise comparison.
// ----------------------------------------------------------------------------
// One point is taken per transaction. After the seventh point the input
// stalls for the evaluation: each of the 35 triples takes a fetch and a
// geometry step (only these when the triple is collinear); any other triple
// adds a key step, a binary gcd over the four key terms (one shift or
// subtract per cycle) and a restoring divide of the four key terms (one bit
// per cycle). Then one compare per pair of keys through two registered key
// memory reads, up to 595 pairs.
// The result is held in an output register until it is taken; a new result
// waits, with the input stalled, until the previous one has gone.
module distinct_circle_counter #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dcc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dcc_pkg::out_t  out_data_o
);

  localparam logic [2:0] MaxC = 3'(GRID_SIZE - 1);
  localparam int unsigned KW = dcc_pkg::KeyW;

  dcc_pkg::state_e state_q, state_d;

  logic [5:0] pts_q [dcc_pkg::NumPoints];
  logic [2:0] loaded_q;
  logic [2:0] ti_q, tj_q, tk_q;
  logic       last_q;
  logic [5:0] key_cnt_q, col_cnt_q, dist_q;
  logic [5:0] ci_q, cj_q;
  logic       seen_q;

  logic signed [KW-1:0] x1_q, y1_q, dx1_q, dy1_q, dx2_q, dy2_q, r1_q, r2_q, s1_q;
  logic signed [KW-1:0] ka_q, kb_q, kc_q, det_q;
  logic [KW-1:0] gu_q, gv_q;
  logic [4:0]    gsh_q;
  logic [1:0]    gstep_q;
  logic [1:0]    dsel_q;
  logic [4:0]    dbit_q;
  logic [KW-1:0] dnum_q, drem_q, dquo_q;
  dcc_pkg::key_t key_acc_q;

  dcc_pkg::key_t kmem [dcc_pkg::NumTriples];
  dcc_pkg::key_t rd_i_q, rd_j_q;

  dcc_pkg::out_t res_q;
  logic          res_vld_q;

  logic [2:0] cx, cy;
  assign cx = (in_data_i.px_coord > MaxC) ? MaxC : in_data_i.px_coord;
  assign cy = (in_data_i.py_coord > MaxC) ? MaxC : in_data_i.py_coord;

  logic in_acc;
  assign in_stall_o  = (state_q != dcc_pkg::ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  function automatic logic [KW-1:0] mag(input logic signed [KW-1:0] v);
    return v[KW-1] ? KW'(-v) : KW'(v);
  endfunction

  logic signed [KW-1:0] px1, py1, px2, py2, px3, py3;
  always_comb begin
    px1 = KW'(pts_q[ti_q][2:0]); py1 = KW'(pts_q[ti_q][5:3]);
    px2 = KW'(pts_q[tj_q][2:0]); py2 = KW'(pts_q[tj_q][5:3]);
    px3 = KW'(pts_q[tk_q][2:0]); py3 = KW'(pts_q[tk_q][5:3]);
  end

  logic last_triple;
  assign last_triple = (ti_q == 3'd4) && (tj_q == 3'd5) && (tk_q == 3'd6);

  logic signed [KW-1:0] det_c;
  assign det_c = KW'(dx1_q * dy2_q) - KW'(dx2_q * dy1_q);

  logic [KW-1:0] dden;
  assign dden = gu_q;
  logic [KW:0] dtrial;
  assign dtrial = {drem_q, dnum_q[KW-1]} - {1'b0, dden};

  logic gcd_done;
  assign gcd_done = (gstep_q == 2'd3) && (gv_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcc_pkg::ST_LOAD:   if (in_acc && loaded_q == 3'(dcc_pkg::NumPoints - 1)) begin
        state_d = dcc_pkg::ST_FETCH;
      end
      dcc_pkg::ST_FETCH:  state_d = dcc_pkg::ST_GEOM;
      dcc_pkg::ST_GEOM:   begin
        if (det_c == '0) begin
          state_d = last_triple ? dcc_pkg::ST_CMP_RD : dcc_pkg::ST_FETCH;
        end else begin
          state_d = dcc_pkg::ST_KEYC;
        end
      end
      dcc_pkg::ST_KEYC:   state_d = dcc_pkg::ST_GCD;
      dcc_pkg::ST_GCD:    if (gcd_done) state_d = dcc_pkg::ST_DIV;
      dcc_pkg::ST_DIV:    begin
        if (dsel_q == 2'd3 && dbit_q == 5'(KW - 1)) begin
          state_d = last_q ? dcc_pkg::ST_CMP_RD : dcc_pkg::ST_FETCH;
        end
      end
      dcc_pkg::ST_CMP_RD: begin
        if (ci_q >= key_cnt_q) state_d = dcc_pkg::ST_OUT;
        else if (cj_q < ci_q)  state_d = dcc_pkg::ST_CMP;
      end
      dcc_pkg::ST_CMP:    state_d = dcc_pkg::ST_CMP_RD;
      dcc_pkg::ST_OUT:    if (!res_vld_q) state_d = dcc_pkg::ST_LOAD;
      default:            state_d = dcc_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dcc_pkg::ST_LOAD;
      loaded_q  <= '0;
      res_vld_q <= 1'b0;
      key_cnt_q <= '0;
      col_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (res_vld_q && !out_stall_i) res_vld_q <= 1'b0;
      unique case (state_q)
        dcc_pkg::ST_LOAD: if (in_acc) begin
          if (loaded_q == 3'(dcc_pkg::NumPoints - 1)) begin
            loaded_q  <= '0;
            key_cnt_q <= '0;
            col_cnt_q <= '0;
          end else begin
            loaded_q <= loaded_q + 3'd1;
          end
        end
        dcc_pkg::ST_GEOM: if (det_c == '0) col_cnt_q <= col_cnt_q + 6'd1;
        dcc_pkg::ST_DIV:  if (dsel_q == 2'd3 && dbit_q == 5'(KW - 1)) begin
          key_cnt_q <= key_cnt_q + 6'd1;
        end
        dcc_pkg::ST_OUT:  if (!res_vld_q) res_vld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dcc_pkg::ST_LOAD: if (in_acc) begin
        pts_q[loaded_q] <= {cy, cx};
        ti_q <= 3'd0; tj_q <= 3'd1; tk_q <= 3'd2;
        ci_q <= '0; cj_q <= '0; dist_q <= '0; seen_q <= 1'b0;
      end
      dcc_pkg::ST_FETCH: begin
        x1_q  <= px1; y1_q <= py1;
        dx1_q <= px2 - px1; dy1_q <= py2 - py1;
        dx2_q <= px3 - px1; dy2_q <= py3 - py1;
        s1_q  <= KW'(px1 * px1) + KW'(py1 * py1);
        r1_q  <= KW'(px1 * px1) + KW'(py1 * py1) - KW'(px2 * px2) - KW'(py2 * py2);
        r2_q  <= KW'(px1 * px1) + KW'(py1 * py1) - KW'(px3 * px3) - KW'(py3 * py3);
      end
      dcc_pkg::ST_GEOM: begin
        det_q  <= det_c;
        ka_q   <= KW'(r1_q * dy2_q) - KW'(r2_q * dy1_q);
        kb_q   <= KW'(dx1_q * r2_q) - KW'(dx2_q * r1_q);
        last_q <= last_triple;
        if (tk_q != 3'd6)      tk_q <= tk_q + 3'd1;
        else if (tj_q != 3'd5) begin tj_q <= tj_q + 3'd1; tk_q <= tj_q + 3'd2; end
        else if (ti_q != 3'd4) begin
          ti_q <= ti_q + 3'd1; tj_q <= ti_q + 3'd2; tk_q <= ti_q + 3'd3;
        end
      end
      dcc_pkg::ST_KEYC: begin
        kc_q    <= KW'(-(s1_q * det_q)) - KW'(ka_q * x1_q) - KW'(kb_q * y1_q);
        gu_q    <= mag(ka_q);
        gv_q    <= mag(kb_q);
        gsh_q   <= '0;
        gstep_q <= 2'd0;
      end
      dcc_pkg::ST_GCD: begin
        if (gv_q == '0) begin
          gu_q  <= gu_q << gsh_q;
          gsh_q <= '0;
          unique case (gstep_q)
            2'd0:    begin gv_q <= mag(kc_q); gstep_q <= 2'd1; end
            2'd1:    begin gv_q <= mag(det_q); gstep_q <= 2'd2; end
            default: begin
              gstep_q <= 2'd3;
              dsel_q  <= 2'd0; dbit_q <= '0;
              drem_q  <= '0;   dnum_q <= mag(ka_q);
            end
          endcase
        end else if (gu_q == '0) begin
          gu_q <= gv_q; gv_q <= '0;
        end else if (!gu_q[0] && !gv_q[0]) begin
          gu_q <= gu_q >> 1; gv_q <= gv_q >> 1; gsh_q <= gsh_q + 5'd1;
        end else if (!gu_q[0]) begin
          gu_q <= gu_q >> 1;
        end else if (!gv_q[0]) begin
          gv_q <= gv_q >> 1;
        end else if (gu_q >= gv_q) begin
          gu_q <= gu_q - gv_q;
        end else begin
          gv_q <= gv_q - gu_q;
        end
      end
      dcc_pkg::ST_DIV: begin
        if (dbit_q == 5'(KW - 1)) begin
          logic signed [KW-1:0] q, src;
          q = !dtrial[KW] ? {dquo_q[KW-2:0], 1'b1} : {dquo_q[KW-2:0], 1'b0};
          unique case (dsel_q)
            2'd0:    src = ka_q;
            2'd1:    src = kb_q;
            2'd2:    src = kc_q;
            default: src = det_q;
          endcase
          if (src[KW-1] ^ det_q[KW-1]) q = -q;
          unique case (dsel_q)
            2'd0:    key_acc_q.a <= q;
            2'd1:    key_acc_q.b <= q;
            2'd2:    key_acc_q.c <= q;
            default: kmem[key_cnt_q] <= '{a: key_acc_q.a, b: key_acc_q.b,
                                           c: key_acc_q.c, d: q};
          endcase
          dsel_q <= dsel_q + 2'd1;
          dbit_q <= '0;
          drem_q <= '0;
          dquo_q <= '0;
          unique case (dsel_q)
            2'd0:    dnum_q <= mag(kb_q);
            2'd1:    dnum_q <= mag(kc_q);
            default: dnum_q <= mag(det_q);
          endcase
        end else begin
          if (!dtrial[KW]) begin
            drem_q <= dtrial[KW-1:0];
            dquo_q <= {dquo_q[KW-2:0], 1'b1};
          end else begin
            drem_q <= {drem_q[KW-2:0], dnum_q[KW-1]};
            dquo_q <= {dquo_q[KW-2:0], 1'b0};
          end
          dnum_q <= {dnum_q[KW-2:0], 1'b0};
          dbit_q <= dbit_q + 5'd1;
        end
      end
      dcc_pkg::ST_CMP_RD: begin
        if (ci_q < key_cnt_q) begin
          if (cj_q < ci_q) begin
            rd_i_q <= kmem[ci_q];
            rd_j_q <= kmem[cj_q];
          end else begin
            if (!seen_q) dist_q <= dist_q + 6'd1;
            ci_q <= ci_q + 6'd1; cj_q <= '0; seen_q <= 1'b0;
          end
        end
      end
      dcc_pkg::ST_CMP: begin
        if (rd_i_q == rd_j_q) begin
          seen_q <= 1'b1; cj_q <= ci_q;
        end else begin
          cj_q <= cj_q + 6'd1;
        end
      end
      dcc_pkg::ST_OUT: if (!res_vld_q) begin
        res_q.circle_count <= dist_q;
        res_q.degenerate   <= (col_cnt_q == 6'(dcc_pkg::NumTriples)) ||
                              (key_cnt_q == 6'(dcc_pkg::NumTriples) && dist_q == 6'd1);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_out_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcc_pkg::ST_LOAD && loaded_q != '0) |-> !$rose(out_valid_o))
    else $error("result raised mid-set");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_cnt_q + col_cnt_q) <= 7'(dcc_pkg::NumTriples))
    else $error("triple counts overflow");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped under stall");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the distinct circle counter
// Sends sets of seven grid points, predicts the distinct circle count and the
// degenerate flag for each set, and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;

  class circle_board;
    logic [2:0]    px_q[$];
    logic [2:0]    py_q[$];
    dcc_pkg::out_t expected_q[$];
    int            errors;

    function void note_point(dcc_pkg::in_t p);
      px_q.push_back(p.px_coord);
      py_q.push_back(p.py_coord);
      if (px_q.size() == dcc_pkg::NumPoints) begin
        expected_q.push_back(count_circles());
        px_q.delete();
        py_q.delete();
      end
    endfunction

    function longint gcd2(longint u, longint v);
      longint t;
      if (u < 0) u = -u;
      if (v < 0) v = -v;
      while (v != 0) begin
        t = u % v;
        u = v;
        v = t;
      end
      return u;
    endfunction

    function dcc_pkg::out_t count_circles();
      longint ka[35], kb[35], kc[35], kd[35];
      longint x1, y1, x2, y2, x3, y3, dx1, dy1, dx2, dy2, s1, r1, r2, det;
      longint a, b, c, g;
      int     nkeys, ncol, distinct;
      bit     seen;
      dcc_pkg::out_t res;
      nkeys = 0;
      ncol = 0;
      distinct = 0;
      for (int i = 0; i < dcc_pkg::NumPoints; i++)
        for (int j = i + 1; j < dcc_pkg::NumPoints; j++)
          for (int k = j + 1; k < dcc_pkg::NumPoints; k++) begin
            x1 = px_q[i]; y1 = py_q[i];
            x2 = px_q[j]; y2 = py_q[j];
            x3 = px_q[k]; y3 = py_q[k];
            dx1 = x2 - x1; dy1 = y2 - y1;
            dx2 = x3 - x1; dy2 = y3 - y1;
            s1 = x1 * x1 + y1 * y1;
            r1 = -(x2 * x2 + y2 * y2 - s1);
            r2 = -(x3 * x3 + y3 * y3 - s1);
            det = dx1 * dy2 - dx2 * dy1;
            if (det == 0) begin
              ncol++;
            end else begin
              a = r1 * dy2 - r2 * dy1;
              b = dx1 * r2 - dx2 * r1;
              c = -s1 * det - a * x1 - b * y1;
              g = gcd2(gcd2(a, b), gcd2(c, det));
              if (det < 0) g = -g;
              ka[nkeys] = a / g;
              kb[nkeys] = b / g;
              kc[nkeys] = c / g;
              kd[nkeys] = det / g;
              nkeys++;
            end
          end
      for (int i = 0; i < nkeys; i++) begin
        seen = 0;
        for (int j = 0; j < i; j++)
          if (ka[i] == ka[j] && kb[i] == kb[j] && kc[i] == kc[j] && kd[i] == kd[j])
            seen = 1;
        if (!seen) distinct++;
      end
      res.circle_count = 6'(distinct);
      res.degenerate = (ncol == dcc_pkg::NumTriples) ||
                       (nkeys == dcc_pkg::NumTriples && distinct == 1);
      return res;
    endfunction

    function void check_result(dcc_pkg::out_t got);
      dcc_pkg::out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: circle_count %0d degenerate %0d",
               got.circle_count, got.degenerate);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.circle_count !== want.circle_count) begin
        $error("circle_count: expected %0d, actual %0d", want.circle_count,
               got.circle_count);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0d, actual %0d", want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  dcc_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  dcc_pkg::out_t out_data_o;
  circle_board   board = new();
  bit            hold_off = 1'b0;
  bit            sender_done = 1'b0;

  distinct_circle_counter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(logic [2:0] x, logic [2:0] y);
    dcc_pkg::in_t p;
    int           n;
    p.px_coord = x;
    p.py_coord = y;
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    board.note_point(p);
    n = gap_len();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_set(logic [2:0] xs[7], logic [2:0] ys[7]);
    for (int i = 0; i < 7; i++) send_point(xs[i], ys[i]);
  endtask

  task automatic send_random_set(int kind);
    logic [2:0] xs[7], ys[7];
    logic [2:0] c;
    c = 3'($urandom);
    for (int i = 0; i < 7; i++) begin
      case (kind)
        0: begin xs[i] = c; ys[i] = 3'($urandom); end
        1: begin xs[i] = 3'($urandom_range(0, 2)); ys[i] = 3'($urandom_range(0, 2)); end
        default: begin xs[i] = 3'($urandom); ys[i] = 3'($urandom); end
      endcase
    end
    send_set(xs, ys);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if (hold_off) out_stall_i <= 1'b1;
      else out_stall_i <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    logic [2:0] xs[7], ys[7];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // all points on one line
    xs = '{0, 1, 2, 3, 4, 5, 7}; ys = '{0, 1, 2, 3, 4, 5, 7};
    send_set(xs, ys);
    // repeated point throughout
    xs = '{7, 7, 7, 7, 7, 7, 7}; ys = '{7, 7, 7, 7, 7, 7, 7};
    send_set(xs, ys);
    // concyclic points around a centre
    xs = '{3, 0, 6, 3, 3, 6, 0}; ys = '{0, 3, 3, 6, 0, 3, 3};
    send_set(xs, ys);
    // generic spread of extremes
    xs = '{0, 7, 0, 7, 3, 5, 1}; ys = '{0, 0, 7, 7, 4, 2, 6};
    send_set(xs, ys);
    // long receiver hold-off while the sender keeps offering sets
    hold_off = 1'b1;
    fork
      begin repeat (20000) @(posedge clk_i); hold_off = 1'b0; end
      for (int s = 0; s < 3; s++) send_random_set(2);
    join
    in_valid_i <= 1'b0;
    wait (board.expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    for (int s = 0; s < 172; s++) begin
      send_random_set($urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2);
    end
    in_valid_i <= 1'b0;
    wait (board.expected_q.size() == 0);
    repeat (5000) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
